// ===== rtl/pmwis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmwis_pkg
// Shared sizes, types and the step record for the path MWIS core.
// ----------------------------------------------------------------------------
package pmwis_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int WEIGHT_BITS  = 32;
    localparam int TOTAL_BITS   = 39;
    localparam int VTX_BITS     = 8;
    localparam int RESULT_CAP   = 64;

    // vertex count 0..MAX_VERTICES, also the best table index
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int K_W    = $clog2(RESULT_CAP + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = ((VTX_BITS + TOTAL_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // tuser bit positions on the result side
    localparam int USER_EMPTY = 0;
    localparam int USER_OVF   = 1;

    typedef logic [TOTAL_BITS-1:0]  t_best;
    typedef logic [WEIGHT_BITS-1:0] t_weight;

    // one relaxation step: include decision and new best value
    typedef struct packed {
        logic  take;
        t_best best;
    } t_step;

endpackage

// ===== rtl/path_max_weight_independent_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_max_weight_independent_set_core
// Max-weight independent set on a path graph: loads vertex weights, runs the
// DP over a weight RAM into a best-value RAM, then walks back and streams the
// chosen vertices in descending order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata[31:0] weight, tlast last vertex
//  m_axis    out  tdata[7:0] vertex, tdata[46:8] total; tuser[0] empty_res,
//                 tuser[1] overflow; tlast final_res
//
//  Loading takes one item per cycle. After the item with tlast the input
//  stalls through the forward pass (one weight RAM read per vertex), the
//  backward walk (best RAM read and decision per visited vertex) and the
//  close of the run (end check, last item); output backpressure stretches
//  the walk.
//  Reset (i_rst_n low, synchronous) empties the run; RAMs need no clearing.
// ----------------------------------------------------------------------------
module path_max_weight_independent_set_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pmwis_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // weight
    input  logic                               s_axis_tlast,  // last
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pmwis_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // vertex, total, pad
    output logic [pmwis_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // empty_res, overflow
    output logic                               m_axis_tlast   // final_res
);
    import pmwis_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FWD,
        S_WALK_RD,
        S_WALK_CHK,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_iss;
    logic                 r_pv;
    logic [CNT_W-1:0]     r_pi;
    t_best                r_b1;
    t_best                r_b2;
    t_best                r_total;
    logic [CNT_W-1:0]     r_wi;
    logic [K_W-1:0]       r_k;
    logic [CNT_W-1:0]     r_pend;

    logic                 r_ovalid;
    logic [VTX_BITS-1:0]  r_ovtx;
    t_best                r_otot;
    logic                 r_oempty;
    logic                 r_oovf;
    logic                 r_olast;

    // weight RAM and best RAM ({take, best(i)} at index i)
    t_weight              r_wmem [MAX_VERTICES];
    t_weight              r_wrdata;
    t_step                r_bmem [MAX_VERTICES + 1];
    t_step                r_brdata;

    logic                 in_acc;
    logic                 has_room;
    logic [CNT_W-1:0]     count_after;
    logic                 oslot;
    logic                 out_load;
    logic [ADDR_W-1:0]    w_raddr;
    logic                 b_we;
    t_step                step;

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign has_room      = (r_count < CNT_W'(MAX_VERTICES));
    assign count_after   = has_room ? r_count + CNT_W'(1) : r_count;
    assign oslot         = !r_ovalid || m_axis_tready;
    assign w_raddr       = ADDR_W'(r_idx - CNT_W'(1));
    assign b_we          = (r_state == S_FWD) && r_pv;

    // a new result item is loaded: held pick on a newer take, or run close
    assign out_load = oslot &&
                      (((r_state == S_WALK_CHK) && r_brdata.take && (r_k != '0)) ||
                       (r_state == S_FIN));

    always_ff @(posedge i_clk) begin
        if (in_acc && has_room) begin
            r_wmem[r_count[ADDR_W-1:0]] <= s_axis_tdata[WEIGHT_BITS-1:0];
        end
        r_wrdata <= r_wmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_bmem[r_pi] <= step;
        end
        r_brdata <= r_bmem[r_wi];
    end

    pmwis_relax u_relax (
        .i_prev1  (r_b1),
        .i_prev2  (r_b2),
        .i_weight (r_wrdata),
        .o_step   (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_iss    <= 1'b0;
            r_pv     <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_pv <= (r_state == S_FWD) && r_iss;
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= count_after;
                        if (!has_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_n   <= count_after;
                            r_idx <= CNT_W'(1);
                            r_iss <= (count_after != '0);
                            r_b1  <= '0;
                            r_b2  <= '0;
                            r_k   <= '0;
                            r_wi  <= '0;
                            r_state <= (count_after == '0) ? S_WALK_RD : S_FWD;
                        end
                    end
                end
                S_FWD: begin
                    if (r_iss) begin
                        r_pi  <= r_idx;
                        r_idx <= r_idx + CNT_W'(1);
                        r_iss <= (r_idx != r_n);
                    end
                    if (r_pv) begin
                        r_b2 <= r_b1;
                        r_b1 <= step.best;
                        if (r_pi == r_n) begin
                            r_total <= step.best;
                            r_wi    <= r_n;
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_WALK_RD: begin
                    // best RAM is read at r_wi during this cycle
                    if (r_wi == '0 || r_k == K_W'(RESULT_CAP)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_WALK_CHK;
                    end
                end
                S_WALK_CHK: begin
                    if (r_brdata.take) begin
                        // the held vertex goes out once a newer one is found
                        if (r_k == '0 || oslot) begin
                            if (r_k != '0) begin
                                r_ovtx   <= VTX_BITS'(r_pend);
                                r_otot   <= r_total;
                                r_oempty <= 1'b0;
                                r_oovf   <= r_ovf;
                                r_olast  <= 1'b0;
                            end
                            r_pend  <= r_wi;
                            r_k     <= r_k + K_W'(1);
                            r_wi    <= (r_wi >= CNT_W'(2)) ? r_wi - CNT_W'(2) : '0;
                            r_state <= S_WALK_RD;
                        end
                    end else begin
                        r_wi    <= r_wi - CNT_W'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_FIN: begin
                    if (oslot) begin
                        r_oovf   <= r_ovf;
                        r_olast  <= 1'b1;
                        if (r_k != '0) begin
                            r_ovtx   <= VTX_BITS'(r_pend);
                            r_otot   <= r_total;
                            r_oempty <= 1'b0;
                        end else begin
                            r_ovtx   <= '0;
                            r_otot   <= '0;
                            r_oempty <= 1'b1;
                        end
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_DATA_W'({r_otot, r_ovtx});
    assign m_axis_tlast  = r_olast;

    always_comb begin
        m_axis_tuser             = '0;
        m_axis_tuser[USER_EMPTY] = r_oempty;
        m_axis_tuser[USER_OVF]   = r_oovf;
    end

endmodule

// ===== rtl/pmwis_relax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmwis_relax
// One step of the path recurrence: best(i) = max(best(i-1), best(i-2)+w(i)),
// saturating add, ties exclude the vertex.
// ----------------------------------------------------------------------------
module pmwis_relax (
    input  pmwis_pkg::t_best   i_prev1,
    input  pmwis_pkg::t_best   i_prev2,
    input  pmwis_pkg::t_weight i_weight,
    output pmwis_pkg::t_step   o_step
);
    import pmwis_pkg::*;

    logic [TOTAL_BITS:0] sum;
    t_best               incl;

    assign sum  = {1'b0, i_prev2} + (TOTAL_BITS + 1)'(i_weight);
    assign incl = sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];

    always_comb begin
        o_step.take = (i_prev1 < incl);
        o_step.best = o_step.take ? incl : i_prev1;
    end

endmodule

// ===== rtl/pmwis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmwis_checker
// Port-level checks for the path MWIS core, bound to the top level.
// ----------------------------------------------------------------------------
module pmwis_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pmwis_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [pmwis_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input logic                               m_axis_tlast
);
    import pmwis_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // empty set: single final item with vertex 0
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_EMPTY] |->
            m_axis_tlast && m_axis_tdata[VTX_BITS-1:0] == '0)
        else $error("empty result not final or vertex nonzero");

    // chosen vertices are 1-based
    a_vtx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_EMPTY] |->
            m_axis_tdata[VTX_BITS-1:0] != '0)
        else $error("chosen vertex index is zero");

    // mid-run results mean the walk is still going, so no loading
    a_no_load_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while run still emitting");

endmodule

bind path_max_weight_independent_set_core pmwis_checker u_pmwis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/path_max_weight_independent_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_max_weight_independent_set_checker
// Watches both streams of the path MWIS core. Stores each accepted weight,
// solves the path on the item with tlast and queues the chosen vertices in
// descending order. Each result item is compared field by field with the
// oldest queued pick.
// ----------------------------------------------------------------------------
module path_max_weight_independent_set_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [pmwis_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // weight
    input  logic                                s_axis_tlast,  // last
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [pmwis_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // vertex, total, pad
    input  logic [pmwis_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // empty_res, overflow
    input  logic                                m_axis_tlast,  // final_res
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import pmwis_pkg::*;

    typedef struct packed {
        logic [VTX_BITS-1:0] vertex;
        t_best               total;
        logic                empty;
        logic                ovf;
        logic                fin;
    } t_mwis_pick;

    localparam t_best BEST_CEIL = '1;

    t_weight    path_weights [MAX_VERTICES];
    t_best      best_sum [MAX_VERTICES+1];
    int         path_len = 0;
    logic       dropped = 1'b0;
    t_mwis_pick picks_q [$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_best add_capped(input t_best a, input t_weight b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + b;
        return (s > {1'b0, BEST_CEIL}) ? BEST_CEIL : s[TOTAL_BITS-1:0];
    endfunction

    // DP forward, then backward walk; ties leave the vertex out
    task automatic solve_path();
        int         i;
        int         k;
        int         j;
        t_best      prev2;
        t_best      incl;
        int         chosen [RESULT_CAP];
        t_mwis_pick r;
        best_sum[0] = '0;
        for (i = 1; i <= path_len; i++) begin
            prev2 = (i >= 2) ? best_sum[i-2] : '0;
            incl = add_capped(prev2, path_weights[i-1]);
            best_sum[i] = (best_sum[i-1] >= incl) ? best_sum[i-1] : incl;
        end
        i = path_len;
        k = 0;
        while (i >= 1 && k < RESULT_CAP) begin
            prev2 = (i >= 2) ? best_sum[i-2] : '0;
            incl = add_capped(prev2, path_weights[i-1]);
            if (best_sum[i-1] >= incl) begin
                i = i - 1;
            end else begin
                chosen[k] = i;
                k++;
                i = (i >= 2) ? i - 2 : 0;
            end
        end
        r.ovf = dropped;
        if (k == 0) begin
            r.vertex = '0;
            r.total  = '0;
            r.empty  = 1'b1;
            r.fin    = 1'b1;
            picks_q.insert(picks_q.size(), r);
        end else begin
            for (j = 0; j < k; j++) begin
                r.vertex = VTX_BITS'(chosen[j]);
                r.total  = best_sum[path_len];
                r.empty  = 1'b0;
                r.fin    = (j == k - 1);
                picks_q.insert(picks_q.size(), r);
            end
        end
        path_len = 0;
        dropped = 1'b0;
    endtask

    task automatic check_result();
        t_mwis_pick          want;
        logic [VTX_BITS-1:0] got_vertex;
        t_best               got_total;
        logic                got_empty;
        logic                got_ovf;
        got_vertex = m_axis_tdata[VTX_BITS-1:0];
        got_total  = m_axis_tdata[VTX_BITS +: TOTAL_BITS];
        got_empty  = m_axis_tuser[USER_EMPTY];
        got_ovf    = m_axis_tuser[USER_OVF];
        if (picks_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result vertex %0d total %0d",
                                      got_vertex, got_total));
        end else begin
            want = picks_q.pop_front();
            if (got_vertex !== want.vertex || got_total !== want.total ||
                got_empty !== want.empty || got_ovf !== want.ovf ||
                m_axis_tlast !== want.fin) begin
                report_mismatch($sformatf(
                    "vtx %0d/%0d total %0d/%0d empty %b/%b ovf %b/%b last %b/%b",
                    got_vertex, want.vertex, got_total, want.total,
                    got_empty, want.empty, got_ovf, want.ovf,
                    m_axis_tlast, want.fin));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            path_len = 0;
            dropped = 1'b0;
            picks_q.delete();
            o_pending <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (path_len < MAX_VERTICES) begin
                    path_weights[path_len] = s_axis_tdata[WEIGHT_BITS-1:0];
                    path_len++;
                end else begin
                    dropped = 1'b1;
                end
                if (s_axis_tlast) begin
                    solve_path();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            o_pending <= picks_q.size();
        end
    end

endmodule

// ===== tb/tb_path_max_weight_independent_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_path_max_weight_independent_set_core
// Feeds paths of vertex weights to the MWIS core: a few hand-picked paths
// (ties, zero and all-ones weights, empty sets), then random paths of mixed
// weight profiles, including one past capacity and one exactly full. Both
// sides idle at random; the checker judges every result item.
// ----------------------------------------------------------------------------
module tb_path_max_weight_independent_set_core;
    import pmwis_pkg::*;

    typedef enum int { MIX_FULL, MIX_TIES, MIX_SPARSE, MIX_HIGH } t_weight_mix;

    localparam int RANDOM_ITEMS = 340;
    localparam int DRAIN_CYCLES = 4 * MAX_VERTICES + 16;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   items_sent = 0;
    logic steady = 1'b0;

    path_max_weight_independent_set_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    path_max_weight_independent_set_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    // result side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_weight(input logic [IN_DATA_W-1:0] w, input logic lst);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [IN_DATA_W-1:0] pick_weight(input t_weight_mix mix);
        case (mix)
            MIX_TIES:   return $urandom_range(0, 3);
            MIX_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            MIX_HIGH:   return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_path(input int len, input t_weight_mix mix);
        int j;
        for (j = 0; j < len; j++) begin
            send_weight(pick_weight(mix), j == len - 1);
        end
    endtask

    // sender holds off until the core has returned every pick
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int          run_idx;
        int          random_start;
        int          len;
        t_weight_mix mix;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single vertex, zero weight: empty set
        send_weight(32'h0, 1'b1);
        // single vertex, full weight
        send_weight(32'hFFFF_FFFF, 1'b1);
        // equal neighbors: tie keeps the later vertex out
        send_weight(32'd5, 1'b0);
        send_weight(32'd5, 1'b1);
        // all zero path: empty set
        send_weight(32'h0, 1'b0);
        send_weight(32'h0, 1'b0);
        send_weight(32'h0, 1'b1);
        // middle vertex wins
        send_weight(32'd1, 1'b0);
        send_weight(32'd3, 1'b0);
        send_weight(32'd1, 1'b1);
        // both ends win
        send_weight(32'd4, 1'b0);
        send_weight(32'd5, 1'b0);
        send_weight(32'd4, 1'b1);
        // all-ones weights with chained ties
        repeat (3) send_weight(32'hFFFF_FFFF, 1'b0);
        send_weight(32'hFFFF_FFFF, 1'b1);
        // alternating bit patterns
        send_weight(32'hAAAA_AAAA, 1'b0);
        send_weight(32'h5555_5555, 1'b1);
        hold_until_drained();

        run_idx = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (run_idx == 6) begin
                // past capacity, the tlast item itself is dropped
                len = MAX_VERTICES + $urandom_range(1, 3);
            end else if (run_idx == 12) begin
                len = MAX_VERTICES;
            end else begin
                len = $urandom_range(1, 12);
            end
            mix = t_weight_mix'($urandom_range(0, 3));
            steady <= (run_idx >= 4 && run_idx < 12);
            send_path(len, mix);
            if (run_idx == 8) hold_until_drained();
            run_idx++;
        end
        s_axis_tvalid <= 1'b0;
        steady <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
